[hdl/bmpq_pkg.sv]
`default_nettype none

package bmpq_pkg;

  // Request kinds carried on the input side.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SERVE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_SERVED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam int unsigned PID_W  = 16;
  localparam int unsigned PRIO_W = 8;

  // One stored queue entry.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
  } entry_t;

endpackage

`default_nettype wire

[hdl/bounded_max_priority_queue.sv]
`default_nettype none

// Channel   Dir  tdata (low bit up)                          tuser
// s_*       in   process_id[15:0], priority_req[23:16]       req_type
// m_*       out  served_process[15:0], served_priority[23:16] status[1:0]
//
// Inserts walk the sorted store from the top down, one memory read and one
// write per entry moved. A serve reads the top entry through S_SRV_RD and
// S_SRV_DATA before S_RES; an empty serve or a full insert goes straight to
// S_RES. Reset clears the state, the entry count and m_tvalid; the store
// needs no clearing.
// A result waiting on m_tready does not block the next transfer on s_*, but the
// block does not finish that next request until the output register is free.
module bounded_max_priority_queue
  import bmpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // process_id[15:0], priority_req[23:16]
  input  wire logic        s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // served_process[15:0], served_priority[23:16]
  output logic [1:0]       m_tuser    // status
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_SRV_RD   = 3'd3;
  localparam logic [2:0] S_SRV_DATA = 3'd4;
  localparam logic [2:0] S_RES      = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  entry_t           new_entry;
  logic [1:0]       res_status;
  entry_t           res_entry;

  entry_t           mem [CAPACITY];
  entry_t           rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [CNT_W-1:0] idx_dec;
  logic             s_fire;
  logic             out_free;

  assign s_fire   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign idx_dec  = idx - 1'b1;

  // Store read address: the entry below the hole during an insert, else the top.
  always_comb begin
    if (state == S_INS_RD) begin
      rd_addr = idx_dec[ADDR_W-1:0];
    end else begin
      rd_addr = count[ADDR_W-1:0];
    end
  end

  // Store write: move an entry up one place, or drop the new entry into the hole.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[ADDR_W-1:0];
    wr_data = new_entry;
    if (state == S_INS_RD && idx == '0) begin
      wr_en = 1'b1;
    end else if (state == S_INS_CMP) begin
      wr_en = 1'b1;
      if (rd_data.prio > new_entry.prio) begin
        wr_data = rd_data;
      end
    end
  end

  // Entry store with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A result loaded in S_RES replaces the one leaving in the same cycle.
      if (m_tvalid && m_tready && state != S_RES) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            new_entry.pid  <= s_tdata[15:0];
            new_entry.prio <= s_tdata[23:16];
            res_entry      <= '0;
            if (s_tuser == REQ_INSERT) begin
              if (count >= CNT_FULL) begin
                res_status <= ST_FULL;
                state      <= S_RES;
              end else begin
                res_status <= ST_INSERTED;
                idx        <= count;
                count      <= count + 1'b1;
                state      <= S_INS_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_RES;
              end else begin
                res_status <= ST_SERVED;
                count      <= count - 1'b1;
                state      <= S_SRV_RD;
              end
            end
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            state <= S_RES;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          // A greater priority below the hole moves up; otherwise the hole is home.
          if (rd_data.prio > new_entry.prio) begin
            idx   <= idx_dec;
            state <= S_INS_RD;
          end else begin
            state <= S_RES;
          end
        end
        S_SRV_RD: begin
          state <= S_SRV_DATA;
        end
        S_SRV_DATA: begin
          res_entry <= rd_data;
          state     <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= res_entry;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
